// ===== rtl/core/epoch_seconds_to_calendar_defines.svh =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: assertion macros
// Concurrent assertion wrappers for the converter RTL of this block.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked assertion, muted while reset is held
`define ES2C_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset
`define ES2C_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ES2C_ASSERT(label, clk, rst_n, prop, msg)
`define ES2C_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/es2cal_pkg.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: package
// Constants, result layout and calendar helper functions.
// ----------------------------------------------------------------------------
package es2cal_pkg;

  // Reciprocal constants and divisors for the shared multiplier.
  // A quotient is (x * RECIP) >> shift, exact over the operand range used:
  //   days   = ((t >> 7)    * ceil(2^35 / 675)) >> 35, t < 2^32
  //   hour   = ((tod >> 4)  * ceil(2^21 / 225)) >> 21, tod < 86400
  //   minute = ((soh >> 2)  * ceil(2^14 / 15))  >> 14, soh < 3600
  //   week   = (wnum        * ceil(2^19 / 7))   >> 19, wnum < 2^16
  localparam logic [25:0] RECIP_DAY     = 26'd50903317;
  localparam logic [25:0] RECIP_HOUR    = 26'd9321;
  localparam logic [25:0] RECIP_MIN     = 26'd1093;
  localparam logic [25:0] RECIP_WEEK    = 26'd74899;
  localparam logic [25:0] SECS_PER_DAY  = 26'd86400;
  localparam logic [25:0] SECS_PER_HOUR = 26'd3600;
  localparam logic [25:0] SECS_PER_MIN  = 26'd60;
  localparam logic [25:0] DAYS_PER_WEEK = 26'd7;

  // 1970-01-01 was a Thursday
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;
  // 1970 counted from 1900
  localparam logic [7:0]  EPOCH_YEAR_OFS = 8'd70;

  localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
  localparam logic [8:0]  DAYS_LEAP_YEAR   = 9'd366;
  // Day of year of February 28 and February 29
  localparam logic [8:0]  FEB28_YDAY = 9'd58;
  localparam logic [8:0]  FEB29_YDAY = 9'd59;

  localparam logic [3:0]  LAST_MONTH = 4'd11;

  // Result item, second in the lowest bits
  typedef struct packed {
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [8:0] day_of_year;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_result_t;

  // Cumulative days before each month of a common year
  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Gregorian leap rule for years 1900..2155 given as offset from 1900:
  // 1900 and 2100 are the only century years that are not leap here
  function automatic logic is_leap(input logic [7:0] yofs);
    return (yofs[1:0] == 2'b00) && (yofs != 8'd0) && (yofs != 8'd200);
  endfunction

endpackage

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to UTC calendar
// Breaks an unsigned 32-bit seconds-since-1970 count into UTC calendar fields
// with one shared multiplier and one subtractor under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                    | Payload
//  ---------+--------------------------+-------------------------------------
//  input    | in_tvalid/tready/tdata   | epoch_seconds [31:0]
//  result   | out_tvalid/tready/tdata  | second..day_of_month, 46 bits in 48
//
//  An item runs from acceptance to result through 8 multiply steps
//  (reciprocal quotient, then remainder, for days, hour, minute and
//  weekday), Y = years elapsed since 1970 plus one year walk steps,
//  M = 1..12 month scan steps and a publish step; the year walk dominates.
//  Reset is synchronous, active low, and clears the sequencer and out_tvalid.
//  in_tready is high only while idle; publish waits for a free output register.
//
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                   // [19:17] weekday, [27:20] years_since_1900,
                                   // [36:28] day_of_year, [40:37] month,
                                   // [45:41] day_of_month, [47:46] zero
);

`include "epoch_seconds_to_calendar_defines.svh"

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY_Q,
    ST_DAY_R,
    ST_HOUR_Q,
    ST_HOUR_R,
    ST_MIN_Q,
    ST_MIN_R,
    ST_WDAY_Q,
    ST_WDAY_R,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [31:0]             num_r, num_nxt;
  logic [15:0]             days_r, days_nxt;
  logic [16:0]             tod_r, tod_nxt;
  logic [11:0]             soh_r, soh_nxt;
  logic [15:0]             wnum_r, wnum_nxt;
  logic [12:0]             wq_r, wq_nxt;
  logic [5:0]              sec_r, sec_nxt;
  logic [5:0]              min_r, min_nxt;
  logic [4:0]              hour_r, hour_nxt;
  logic [2:0]              wday_r, wday_nxt;
  logic [7:0]              year_r, year_nxt;
  logic [8:0]              yday_r, yday_nxt;
  logic [8:0]              d_r, d_nxt;
  logic [3:0]              mon_r, mon_nxt;
  logic [4:0]              mday_r, mday_nxt;
  logic                    out_valid_r, out_valid_nxt;
  es2cal_pkg::cal_result_t out_data_r, out_data_nxt;

  // Shared multiplier and subtractor
  logic [25:0] mul_a, mul_b;
  logic [51:0] mul_p;
  logic [15:0] sub_a, sub_b;
  logic [16:0] sub_d;
  logic        sub_ge;
  logic        leap;
  logic        in_fire;

  assign leap    = es2cal_pkg::is_leap(year_r);
  assign in_fire = in_tvalid && in_tready;

  // Operand select for the one multiplier
  always_comb begin
    case (state_r)
      ST_DAY_Q: begin
        mul_a = {1'b0, num_r[31:7]};
        mul_b = es2cal_pkg::RECIP_DAY;
      end
      ST_DAY_R: begin
        mul_a = {10'd0, days_r};
        mul_b = es2cal_pkg::SECS_PER_DAY;
      end
      ST_HOUR_Q: begin
        mul_a = {13'd0, tod_r[16:4]};
        mul_b = es2cal_pkg::RECIP_HOUR;
      end
      ST_HOUR_R: begin
        mul_a = {21'd0, hour_r};
        mul_b = es2cal_pkg::SECS_PER_HOUR;
      end
      ST_MIN_Q: begin
        mul_a = {16'd0, soh_r[11:2]};
        mul_b = es2cal_pkg::RECIP_MIN;
      end
      ST_MIN_R: begin
        mul_a = {20'd0, min_r};
        mul_b = es2cal_pkg::SECS_PER_MIN;
      end
      ST_WDAY_Q: begin
        mul_a = {10'd0, wnum_r};
        mul_b = es2cal_pkg::RECIP_WEEK;
      end
      ST_WDAY_R: begin
        mul_a = {13'd0, wq_r};
        mul_b = es2cal_pkg::DAYS_PER_WEEK;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Operand select for the one subtractor
  always_comb begin
    case (state_r)
      ST_YEAR: begin
        sub_a = days_r;
        sub_b = {7'd0, leap ? es2cal_pkg::DAYS_LEAP_YEAR : es2cal_pkg::DAYS_COMMON_YEAR};
      end
      ST_MONTH: begin
        sub_a = {7'd0, d_r};
        sub_b = {7'd0, es2cal_pkg::days_before_month(mon_r)};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = ~sub_d[16];

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    days_nxt      = days_r;
    tod_nxt       = tod_r;
    soh_nxt       = soh_r;
    wnum_nxt      = wnum_r;
    wq_nxt        = wq_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    wday_nxt      = wday_r;
    year_nxt      = year_r;
    yday_nxt      = yday_r;
    d_nxt         = d_r;
    mon_nxt       = mon_r;
    mday_nxt      = mday_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          num_nxt   = in_tdata;
          state_nxt = ST_DAY_Q;
        end
      end

      // seconds / 86400 -> whole days
      ST_DAY_Q: begin
        days_nxt  = mul_p[50:35];
        state_nxt = ST_DAY_R;
      end

      // time of day; remainder fits in 17 bits so low bits suffice
      ST_DAY_R: begin
        tod_nxt   = num_r[16:0] - mul_p[16:0];
        wnum_nxt  = days_r + es2cal_pkg::EPOCH_WEEKDAY;
        state_nxt = ST_HOUR_Q;
      end

      // time of day / 3600 -> hour
      ST_HOUR_Q: begin
        hour_nxt  = mul_p[25:21];
        state_nxt = ST_HOUR_R;
      end

      // seconds within the hour
      ST_HOUR_R: begin
        soh_nxt   = tod_r[11:0] - mul_p[11:0];
        state_nxt = ST_MIN_Q;
      end

      // seconds of the hour / 60 -> minute
      ST_MIN_Q: begin
        min_nxt   = mul_p[19:14];
        state_nxt = ST_MIN_R;
      end

      // seconds within the minute
      ST_MIN_R: begin
        sec_nxt   = soh_r[5:0] - mul_p[5:0];
        state_nxt = ST_WDAY_Q;
      end

      // (days + 4) / 7
      ST_WDAY_Q: begin
        wq_nxt    = mul_p[31:19];
        state_nxt = ST_WDAY_R;
      end

      // (days + 4) mod 7 -> weekday
      ST_WDAY_R: begin
        wday_nxt  = wnum_r[2:0] - mul_p[2:0];
        year_nxt  = es2cal_pkg::EPOCH_YEAR_OFS;
        state_nxt = ST_YEAR;
      end

      // Take away whole years until the day of year is left
      ST_YEAR: begin
        if (sub_ge) begin
          days_nxt = sub_d[15:0];
          year_nxt = year_r + 8'd1;
        end else begin
          yday_nxt = days_r[8:0];
          d_nxt    = days_r[8:0];
          mday_nxt = 5'd1;
          // Fold leap years onto the common-year table
          if (leap && (days_r[8:0] > es2cal_pkg::FEB28_YDAY)) begin
            d_nxt = days_r[8:0] - 9'd1;
            if (days_r[8:0] == es2cal_pkg::FEB29_YDAY) begin
              mday_nxt = 5'd2;
            end
          end
          mon_nxt   = es2cal_pkg::LAST_MONTH;
          state_nxt = ST_MONTH;
        end
      end

      // Scan months downward until the table entry fits
      ST_MONTH: begin
        if (sub_ge) begin
          mday_nxt  = mday_r + sub_d[4:0];
          state_nxt = ST_DONE;
        end else begin
          mon_nxt = mon_r - 4'd1;
        end
      end

      // Publish once the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt.second           = sec_r;
          out_data_nxt.minute           = min_r;
          out_data_nxt.hour             = hour_r;
          out_data_nxt.weekday          = wday_r;
          out_data_nxt.years_since_1900 = year_r;
          out_data_nxt.day_of_year      = yday_r;
          out_data_nxt.month            = mon_r;
          out_data_nxt.day_of_month     = mday_r;
          out_valid_nxt                 = 1'b1;
          state_nxt                     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r      <= num_nxt;
    days_r     <= days_nxt;
    tod_r      <= tod_nxt;
    soh_r      <= soh_nxt;
    wnum_r     <= wnum_nxt;
    wq_r       <= wq_nxt;
    sec_r      <= sec_nxt;
    min_r      <= min_nxt;
    hour_r     <= hour_nxt;
    wday_r     <= wday_nxt;
    year_r     <= year_nxt;
    yday_r     <= yday_nxt;
    d_r        <= d_nxt;
    mon_r      <= mon_nxt;
    mday_r     <= mday_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

  // Checks
  `ES2C_ASSERT(a_accept_starts_divide, clk, rst_n,
               in_fire |=> (state_r == ST_DAY_Q), "accepted transaction did not start")
  `ES2C_ASSERT(a_hour_in_range, clk, rst_n,
               (state_r == ST_HOUR_R) |-> (hour_r <= 5'd23), "hour out of range")
  `ES2C_ASSERT(a_year_in_range, clk, rst_n,
               (state_r == ST_YEAR) |-> (year_r <= 8'd206), "year walk ran past 2106")
  `ES2C_ASSERT(a_month_day_folded, clk, rst_n,
               (state_r == ST_MONTH) |-> (d_r <= 9'd364), "folded day of year out of range")
  `ES2C_ASSERT(a_mday_nonzero, clk, rst_n,
               out_tvalid |-> (out_tdata[45:41] != 5'd0), "day of month is zero")

endmodule

// ===== bench/tb_epoch_seconds_to_calendar.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: testbench
// Feeds 32-bit second counts into the converter and checks every broken-down
// UTC result against an in-bench calendar predictor. Covers directed dates
// (epoch, leap days, century rule, year ends, top of range) and then random
// counts weighted toward year, month and day boundaries, with bursty input
// and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;

  localparam int unsigned CLK_HALF       = 10;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned RANDOM_ITEMS   = 1530;
  // Pad of quiet cycles after the last result
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT    = 2500000;
  localparam int unsigned MAX_PRINTED    = 40;

  localparam int unsigned DAY_SECS       = 86400;
  localparam int unsigned HOUR_SECS      = 3600;
  localparam int unsigned MIN_SECS       = 60;
  localparam int unsigned FIRST_YEAR     = 1970;
  localparam int unsigned LAST_YEAR      = 2106;
  localparam int unsigned BASE_YEAR      = 1900;
  localparam int unsigned EPOCH_DOW      = 4;   // Thursday
  localparam int unsigned LAST_FEB_DOY   = 58;  // Feb 28 day of year
  localparam int unsigned LEAP_DAY_DOY   = 59;  // Feb 29 in a leap year

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the calendar for each accepted count and checks
  // results in order
  // --------------------------------------------------------------------------
  class calendar_scoreboard;
    es2cal_pkg::cal_result_t expected_dates[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned month_start[12];

    function new();
      month_start  = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      mismatches   = 0;
      results_seen = 0;
    endfunction

    static function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function es2cal_pkg::cal_result_t to_calendar(logic [31:0] secs);
      es2cal_pkg::cal_result_t r;
      int unsigned t, tod, days, year, len, doy, d, mon, mday;
      t    = secs;
      tod  = t % DAY_SECS;
      days = t / DAY_SECS;
      r.second  = 6'(tod % MIN_SECS);
      r.minute  = 6'((tod / MIN_SECS) % 60);
      r.hour    = 5'(tod / HOUR_SECS);
      r.weekday = 3'((EPOCH_DOW + days) % 7);
      // Walk whole years off the day count
      year = FIRST_YEAR;
      len  = leap_year(year) ? 366 : 365;
      while (days >= len) begin
        days -= len;
        year++;
        len = leap_year(year) ? 366 : 365;
      end
      doy  = days;
      d    = doy;
      mday = 1;
      // Leap day is Feb 28 plus one; later days slide back one
      if (leap_year(year) && d > LAST_FEB_DOY) begin
        if (d == LEAP_DAY_DOY) mday = 2;
        d = d - 1;
      end
      mon = 11;
      while (mon > 0 && month_start[mon] > d) mon--;
      mday = mday + d - month_start[mon];
      r.years_since_1900 = 8'(year - BASE_YEAR);
      r.day_of_year      = 9'(doy);
      r.month            = 4'(mon);
      r.day_of_month     = 5'(mday);
      return r;
    endfunction

    function void note_input(logic [31:0] secs);
      expected_dates.push_back(to_calendar(secs));
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction

    task report(string field, logic [63:0] want, logic [63:0] got);
      if (mismatches < MAX_PRINTED)
        $display("[%0t] result %0d: %s expected %0d got %0d",
                 $realtime, results_seen, field, want, got);
      mismatches++;
    endtask

    task check_result(logic [47:0] data);
      es2cal_pkg::cal_result_t got, want;
      got = data[45:0];
      results_seen++;
      if (expected_dates.size() == 0) begin
        report("unexpected transaction", 0, data);
        return;
      end
      want = expected_dates.pop_front();
      if (got.second !== want.second) report("second", want.second, got.second);
      if (got.minute !== want.minute) report("minute", want.minute, got.minute);
      if (got.hour !== want.hour) report("hour", want.hour, got.hour);
      if (got.weekday !== want.weekday) report("weekday", want.weekday, got.weekday);
      if (got.years_since_1900 !== want.years_since_1900)
        report("years_since_1900", want.years_since_1900, got.years_since_1900);
      if (got.day_of_year !== want.day_of_year)
        report("day_of_year", want.day_of_year, got.day_of_year);
      if (got.month !== want.month) report("month", want.month, got.month);
      if (got.day_of_month !== want.day_of_month)
        report("day_of_month", want.day_of_month, got.day_of_month);
      if (data[47:46] !== 2'b00) report("pad bits", 0, data[47:46]);
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;    // [31:0] epoch_seconds
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;          // [5:0] second, [11:6] minute, [16:12] hour,
                                   // [19:17] weekday, [27:20] years_since_1900,
                                   // [36:28] day_of_year, [40:37] month,
                                   // [45:41] day_of_month, [47:46] zero

  calendar_scoreboard sb = new();
  int unsigned cycles = 0;
  logic [5:0]  stall_tick = '0;
  logic [1:0]  stall_mode = '0;

  epoch_seconds_to_calendar i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Monitor: note accepted counts, check accepted results
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver back-pressure: mode picked at random each time stall_tick wraps
  always @(negedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == '0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= stall_tick[3];
    endcase
  end

  // Jan 1 00:00:00 of a year as epoch seconds (wraps past 2106)
  function automatic logic [31:0] year_start(int unsigned y);
    logic [31:0] s;
    s = '0;
    for (int unsigned k = FIRST_YEAR; k < y; k++)
      s += (calendar_scoreboard::leap_year(k) ? 366 : 365) * DAY_SECS;
    return s;
  endfunction

  // One input transaction; returns at the falling edge after acceptance
  task automatic push_seconds(logic [31:0] secs);
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_input(int unsigned n);
    in_tvalid <= 1'b0;
    in_tdata  <= $urandom();
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    logic [31:0] directed[$];
    logic [31:0] secs;
    int unsigned sent, burst, y;
    bit          drained;

    directed = '{
      32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
      32'd86400, 32'd31535999, 32'd31536000,          // end of 1970, start 1971
      32'd68169599, 32'd68169600, 32'd68256000,       // 1972 Feb 28/29, Mar 1
      32'd94694399,                                   // 1972-12-31 leap year end
      32'd951782400, 32'd978220800,                   // 2000 leap day, Dec 31
      32'd4107542399, 32'd4107542400,                 // 2100 is not leap
      32'd4233686400,                                 // 2104 leap day
      32'd2147483647, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed dates, back to back
    foreach (directed[i]) push_seconds(directed[i]);
    wait_all_results();

    // Random counts in bursts
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      for (int unsigned k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: secs = $urandom();
          4: begin
            // Around New Year
            y    = $urandom_range(FIRST_YEAR, LAST_YEAR);
            secs = year_start(y) + $urandom_range(0, 6) - 3;
          end
          5: begin
            // Feb 28 and the two days after it, any year from 1970 to 2105
            y    = $urandom_range(FIRST_YEAR, LAST_YEAR - 1);
            secs = year_start(y) + (LAST_FEB_DOY + $urandom_range(0, 2)) * DAY_SECS
                   + $urandom_range(0, DAY_SECS - 1);
          end
          6: secs = $urandom_range(0, 49710) * DAY_SECS
                    + ($urandom_range(0, 1) ? DAY_SECS - 1 : 0);
          7: secs = 32'hFFFF_FFFF - $urandom_range(0, 200000);
          8: secs = $urandom_range(0, 100000000);
          default: begin
            // Last day of a year, leap or not
            y    = $urandom_range(FIRST_YEAR, LAST_YEAR - 1);
            secs = year_start(y) + 364 * DAY_SECS + $urandom_range(0, 2 * DAY_SECS - 1);
          end
        endcase
        push_seconds(secs);
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        wait_all_results();
        drained = 1'b1;
      end
      idle_input($urandom_range(1, 12));
    end

    // Let everything drain, then pad with quiet cycles
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/es2cal_pkg.sv
rtl/core/epoch_seconds_to_calendar.sv
bench/tb_epoch_seconds_to_calendar.sv
